/* rtl/lot_pkg.sv */
// ----------------------------------------------------------------------------
// lot_pkg: shared types and constants for the line offset table
// widths, op and status codes, sequencer states
// ----------------------------------------------------------------------------
package lot_pkg;
  localparam int unsigned MaxLines   = 1024;
  localparam int unsigned OffsetBits = 32;
  localparam int unsigned WidthBits  = 16;
  localparam int unsigned IdxBits    = $clog2(MaxLines);
  localparam int unsigned CntBits    = IdxBits + 1;

  typedef enum logic [2:0] {
    OP_CLEAR = 3'd0, OP_INSERT = 3'd1, OP_UPDATE = 3'd2, OP_SETW = 3'd3,
    OP_REMOVE = 3'd4, OP_QUERY = 3'd5, OP_LOCPOS = 3'd6, OP_LOCY = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_BAD_INDEX = 2'd1, ST_FULL = 2'd2, ST_BEYOND = 2'd3
  } status_e;

  typedef enum logic [4:0] {
    S_IDLE, S_RD0, S_RD1, S_RD2, S_RD3, S_DECIDE, S_INS_RD, S_INS_WR,
    S_UPD, S_UPD_WR, S_RM_MAX, S_RM_MAX2, S_RM_RD, S_RM_WR, S_SCAN, S_SCAN2,
    S_LOC, S_LOC2, S_LOC_NEXT, S_LOC_NEXT2, S_DIV, S_MUL, S_OUT
  } state_e;

  typedef struct packed {
    logic [2:0]  op;
    logic [10:0] line_sel;
    logic [10:0] line_stop;
    logic [31:0] operand_value;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [9:0]  found_line;
    logic [31:0] line_begin;
    logic [31:0] line_finish;
    logic [31:0] line_top;
    logic [31:0] line_bottom;
    logic [15:0] width_of_line;
    logic        at_line_end;
    logic [15:0] widest;
    logic [10:0] count_of_lines;
  } rsp_t;
endpackage

/* rtl/lot_if.sv */
// ----------------------------------------------------------------------------
// lot_if: valid/ready channel carrying one word of a given type
// source drives valid and payload, sink drives ready
// ----------------------------------------------------------------------------
interface lot_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/lot_ram.sv */
// ----------------------------------------------------------------------------
// lot_ram: generic single port ram
// one write or read a cycle, registered read data
// ----------------------------------------------------------------------------
module lot_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[addr_i] <= wdata_i;
    rdata_o <= mem_q[addr_i];
  end
endmodule

/* rtl/line_offset_table.sv */
// ----------------------------------------------------------------------------
// line_offset_table: sorted table of line end offsets with widest-line tracking
// sequencer over two single port rams and one shared adder unit
// ----------------------------------------------------------------------------
// sequence: each word reads its neighbouring entries, then decides; insert, update
//   and remove then walk each shifted entry; locate pos scans line by line;
//   locate y runs a bit-serial divide; a widest rescan walks every line
// throughput: one word at a time, bounded by the per-entry ram port walk
// reset: async active low; count and widest clear, ram contents undefined
// ----------------------------------------------------------------------------
module line_offset_table (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  lot_if.sink        req_i,
  lot_if.source      rsp_o
);
  import lot_pkg::*;

  state_e state_q, state_d;
  req_t   req_q;
  rsp_t   rsp_q;
  logic   rsp_valid_q;
  logic [7:0] height_q;
  logic [CntBits-1:0] used_q;
  logic [WidthBits-1:0] max_q;

  // shared ram port control
  logic                  e_we, w_we;
  logic [IdxBits-1:0]    addr;
  logic [OffsetBits-1:0] e_wdata, e_rdata;
  logic [WidthBits-1:0]  w_wdata, w_rdata;

  lot_ram #(.Width(OffsetBits), .Depth(MaxLines)) u_end (
    .clk_i, .we_i(e_we), .addr_i(addr), .wdata_i(e_wdata), .rdata_o(e_rdata));
  lot_ram #(.Width(WidthBits), .Depth(MaxLines)) u_wid (
    .clk_i, .we_i(w_we), .addr_i(addr), .wdata_i(w_wdata), .rdata_o(w_rdata));

  // working registers
  logic [CntBits-1:0]    j_q;        // walk index
  logic [OffsetBits-1:0] prev_q;     // end of line before sel
  logic [OffsetBits-1:0] cur_q;      // end of line sel / stop-1
  logic [WidthBits-1:0]  wcur_q;     // width of line sel
  logic [OffsetBits-1:0] diff_q;
  logic [WidthBits-1:0]  acc_q;      // running maximum
  logic [OffsetBits-1:0] last_q;     // last end for locate
  logic [OffsetBits-1:0] lp_q;       // previous end during locate
  logic [OffsetBits:0]   rem_q;      // divide remainder
  logic [OffsetBits-1:0] quo_q;
  logic [5:0]            bit_q;
  logic [OffsetBits+7:0] prod_q;

  logic [CntBits-1:0]    j_d;
  logic [OffsetBits-1:0] prev_d, cur_d, diff_d, last_d, lp_d, quo_d;
  logic [WidthBits-1:0]  wcur_d, acc_d, max_d;
  logic [OffsetBits:0]   rem_d;
  logic [5:0]            bit_d;
  logic [OffsetBits+7:0] prod_d;
  logic [CntBits-1:0]    used_d;
  rsp_t                  rsp_d;
  logic                  rsp_valid_d;

  // shared adder
  logic [OffsetBits-1:0] add_a, add_b, add_y;
  assign add_y = add_a + add_b;

  logic [7:0] heff;
  assign heff = (height_q == 8'd0) ? 8'd1 : height_q;

  // line index times height, 11 by 8 bits
  logic [18:0] mul_y;
  assign mul_y = 19'(req_q.line_sel) * 19'(heff);

  logic [CntBits-1:0] n_rm;
  assign n_rm = req_q.line_stop - req_q.line_sel;

  assign req_i.ready = (state_q == S_IDLE) && !rsp_valid_q;
  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.data  = rsp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      rsp_valid_q <= 1'b0;
      height_q <= 8'd16;
      used_q <= '0;
      max_q <= '0;
    end else begin
      state_q <= state_d;
      rsp_valid_q <= rsp_valid_d;
      used_q <= used_d;
      max_q <= max_d;
      if (cfg_we_i) height_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) req_q <= req_i.data;
    rsp_q <= rsp_d; j_q <= j_d; prev_q <= prev_d; cur_q <= cur_d;
    wcur_q <= wcur_d; diff_q <= diff_d; acc_q <= acc_d; last_q <= last_d;
    lp_q <= lp_d; rem_q <= rem_d; quo_q <= quo_d; bit_q <= bit_d;
    prod_q <= prod_d;
  end

  always_comb begin
    state_d = state_q; rsp_valid_d = rsp_valid_q; rsp_d = rsp_q;
    used_d = used_q; max_d = max_q;
    j_d = j_q; prev_d = prev_q; cur_d = cur_q; wcur_d = wcur_q;
    diff_d = diff_q; acc_d = acc_q; last_d = last_q; lp_d = lp_q;
    rem_d = rem_q; quo_d = quo_q; bit_d = bit_q; prod_d = prod_q;
    e_we = 1'b0; w_we = 1'b0; addr = '0; e_wdata = '0; w_wdata = '0;
    add_a = '0; add_b = '0;
    if (rsp_valid_q && rsp_o.ready) rsp_valid_d = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (req_i.valid && req_i.ready) begin
          rsp_d = '0;
          state_d = S_RD0;
        end
      end
      // read line sel-1 end
      S_RD0: begin
        addr = IdxBits'(req_q.line_sel - 11'd1);
        state_d = S_RD1;
      end
      // capture prev, read line sel
      S_RD1: begin
        prev_d = (req_q.line_sel == '0) ? '0 : e_rdata;
        addr = IdxBits'(req_q.line_sel);
        state_d = S_RD2;
      end
      S_RD2: begin
        cur_d = e_rdata; wcur_d = w_rdata;
        // read stop-1 for remove, else last line for locate
        addr = (req_q.op == OP_REMOVE) ? IdxBits'(req_q.line_stop - 11'd1)
                                       : IdxBits'(used_q - 1'b1);
        state_d = S_RD3;
      end
      // hold the address so the word is still there in decide
      S_RD3: begin
        addr = (req_q.op == OP_REMOVE) ? IdxBits'(req_q.line_stop - 11'd1)
                                       : IdxBits'(used_q - 1'b1);
        state_d = S_DECIDE;
      end
      S_DECIDE: begin
        last_d = e_rdata;
        state_d = S_OUT;
        case (req_q.op)
          OP_CLEAR: begin used_d = '0; max_d = '0; end
          OP_INSERT: begin
            if (req_q.line_sel > used_q) rsp_d.status = ST_BAD_INDEX;
            else if (used_q >= CntBits'(MaxLines)) rsp_d.status = ST_FULL;
            else begin
              add_a = req_q.operand_value; add_b = ~prev_q + 1'b1;
              diff_d = add_y;
              j_d = used_q;
              state_d = S_INS_RD;
            end
          end
          OP_UPDATE: begin
            if (req_q.line_sel >= used_q) rsp_d.status = ST_BAD_INDEX;
            else begin
              add_a = req_q.operand_value; add_b = ~cur_q + 1'b1;
              diff_d = add_y;
              j_d = req_q.line_sel;
              state_d = S_UPD;
            end
          end
          OP_SETW: begin
            if (req_q.line_sel >= used_q) rsp_d.status = ST_BAD_INDEX;
            else if (req_q.operand_value[WidthBits-1:0] != wcur_q) begin
              w_we = 1'b1; addr = IdxBits'(req_q.line_sel);
              w_wdata = req_q.operand_value[WidthBits-1:0];
              if (w_wdata > max_q) max_d = w_wdata;
              else if (wcur_q == max_q) begin
                j_d = '0; acc_d = '0; state_d = S_SCAN;
              end
            end
          end
          OP_REMOVE: begin
            if (!(req_q.line_sel < req_q.line_stop && req_q.line_stop <= used_q))
              rsp_d.status = ST_BAD_INDEX;
            else begin
              // cur holds end of line stop-1 after this state
              cur_d = e_rdata;
              add_a = prev_q; add_b = ~e_rdata + 1'b1;
              diff_d = add_y;
              j_d = req_q.line_sel; acc_d = '0;
              state_d = S_RM_MAX;
            end
          end
          OP_QUERY: begin
            if (req_q.line_sel >= used_q) rsp_d.status = ST_BAD_INDEX;
            else begin
              rsp_d.found_line = req_q.line_sel[9:0];
              rsp_d.line_begin = prev_q; rsp_d.line_finish = cur_q;
              rsp_d.width_of_line = wcur_q;
              prod_d = '0; bit_d = '0; state_d = S_MUL;
            end
          end
          OP_LOCPOS: begin
            if (used_q == '0) ;
            else if (req_q.operand_value > e_rdata) rsp_d.status = ST_BEYOND;
            else begin j_d = '0; lp_d = '0; state_d = S_LOC; end
          end
          default: begin
            if (used_q == '0) rsp_d.status = ST_BAD_INDEX;
            else begin
              rem_d = '0; quo_d = '0; bit_d = 6'd31; state_d = S_DIV;
            end
          end
        endcase
      end
      // insert: move j-1 to j, downward
      S_INS_RD: begin
        if (j_q == CntBits'(req_q.line_sel)) begin
          e_we = 1'b1; w_we = 1'b1; addr = IdxBits'(j_q);
          e_wdata = req_q.operand_value; w_wdata = '0;
          used_d = used_q + 1'b1;
          state_d = S_OUT;
        end else begin
          addr = IdxBits'(j_q - 1'b1);
          state_d = S_INS_WR;
        end
      end
      S_INS_WR: begin
        add_a = e_rdata; add_b = diff_q;
        e_we = 1'b1; w_we = 1'b1; addr = IdxBits'(j_q);
        e_wdata = add_y; w_wdata = w_rdata;
        j_d = j_q - 1'b1;
        state_d = S_INS_RD;
      end
      S_UPD: begin
        if (j_q >= used_q) state_d = S_OUT;
        else begin addr = IdxBits'(j_q); state_d = S_UPD_WR; end
      end
      S_UPD_WR: begin
        add_a = e_rdata; add_b = diff_q;
        e_we = 1'b1; addr = IdxBits'(j_q); e_wdata = add_y;
        j_d = j_q + 1'b1;
        state_d = S_UPD;
      end
      // max over removed range
      S_RM_MAX: begin
        if (j_q >= CntBits'(req_q.line_stop)) begin
          j_d = CntBits'(req_q.line_stop); state_d = S_RM_RD;
        end else begin addr = IdxBits'(j_q); state_d = S_RM_MAX2; end
      end
      S_RM_MAX2: begin
        if (w_rdata > acc_q) acc_d = w_rdata;
        j_d = j_q + 1'b1; state_d = S_RM_MAX;
      end
      S_RM_RD: begin
        if (j_q >= used_q) begin
          used_d = used_q - n_rm;
          if (used_d == '0) max_d = '0;
          else if (acc_q == max_q) begin
            j_d = '0; acc_d = '0; state_d = S_SCAN;
          end else state_d = S_OUT;
          if (used_d == '0 || acc_q != max_q) state_d = S_OUT;
        end else begin addr = IdxBits'(j_q); state_d = S_RM_WR; end
      end
      S_RM_WR: begin
        add_a = e_rdata; add_b = diff_q;
        e_we = 1'b1; w_we = 1'b1; addr = IdxBits'(j_q - n_rm);
        e_wdata = add_y; w_wdata = w_rdata;
        j_d = j_q + 1'b1; state_d = S_RM_RD;
      end
      // full width rescan
      S_SCAN: begin
        if (j_q >= used_q) begin max_d = acc_q; state_d = S_OUT; end
        else begin addr = IdxBits'(j_q); state_d = S_SCAN2; end
      end
      S_SCAN2: begin
        if (w_rdata > acc_q) acc_d = w_rdata;
        j_d = j_q + 1'b1; state_d = S_SCAN;
      end
      // lower bound search
      S_LOC: begin addr = IdxBits'(j_q); state_d = S_LOC2; end
      S_LOC2: begin
        if (j_q < used_q - 1'b1 && e_rdata < req_q.operand_value) begin
          lp_d = e_rdata; j_d = j_q + 1'b1; state_d = S_LOC;
        end else begin
          rsp_d.found_line = j_q[9:0];
          if (req_q.operand_value == e_rdata) begin
            rsp_d.at_line_end = 1'b1;
            rsp_d.line_begin = e_rdata;
            if (e_rdata == last_q || j_q + 1'b1 >= used_q) begin
              rsp_d.line_finish = e_rdata; state_d = S_OUT;
            end else state_d = S_LOC_NEXT;
          end else begin
            rsp_d.line_begin = (j_q == '0) ? '0 : lp_q;
            rsp_d.line_finish = e_rdata; state_d = S_OUT;
          end
        end
      end
      S_LOC_NEXT: begin addr = IdxBits'(j_q + 1'b1); state_d = S_LOC_NEXT2; end
      S_LOC_NEXT2: begin rsp_d.line_finish = e_rdata; state_d = S_OUT; end
      // restoring divide, one bit a cycle
      S_DIV: begin
        rem_d = {rem_q[OffsetBits-1:0], req_q.operand_value[bit_q[4:0]]};
        quo_d = {quo_q[OffsetBits-2:0], 1'b0};
        if (rem_d >= (OffsetBits+1)'(heff)) begin
          rem_d = rem_d - (OffsetBits+1)'(heff); quo_d[0] = 1'b1;
        end
        bit_d = bit_q - 1'b1;
        if (bit_q == 6'd0) begin
          if (quo_d >= OffsetBits'(used_q)) rsp_d.found_line = 10'(used_q - 1'b1);
          else rsp_d.found_line = quo_d[9:0];
          state_d = S_OUT;
        end
      end
      // sel*h by one multiply then add h
      S_MUL: begin
        prod_d = (OffsetBits+8)'(mul_y);
        bit_d = bit_q + 1'b1;
        if (bit_q == 6'd1) begin
          rsp_d.line_top = prod_q[OffsetBits-1:0];
          add_a = prod_q[OffsetBits-1:0]; add_b = OffsetBits'(heff);
          rsp_d.line_bottom = add_y;
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        rsp_d.widest = max_q; rsp_d.count_of_lines = used_q;
        rsp_valid_d = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.ready |-> state_q == S_IDLE) else $error("ready while busy");
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CntBits'(MaxLines)) else $error("line count overflow");
  a_one_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_OUT |-> !rsp_valid_q) else $error("result overwritten");
endmodule
